// ===== sv/srtt_pkg.sv =====
// ----------------------------------------------------------------------------
// srtt_pkg
// Shared constants, control/status types and the digit lookup for the
// signed radix to text unit.
// ----------------------------------------------------------------------------
package srtt_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int CHUNK_BITS         = 8;   // quotient bits resolved per divide cycle
   localparam int RADIX_BITS         = 5;
   localparam int CHAR_BITS          = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [CHAR_BITS-1:0]  CHAR_MINUS  = 7'h2D;

   typedef struct packed {
      logic load_item;    // capture sign and magnitude of a new word
      logic div_step;     // resolve one chunk of quotient bits
      logic digit_done;   // push remainder as a digit, restart remainder
      logic emit_sign;    // load '-' into the output register
      logic emit_digit;   // pop the top digit into the output register
      logic last_digit;   // mark the popped digit as last
   } srtt_cmd_type;

   typedef struct packed {
      logic out_free;     // output register can take a word this cycle
      logic quot_zero;    // quotient after this step is zero
      logic negative;     // captured word was negative
   } srtt_status_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] digit);
      logic [CHAR_BITS-1:0] c;
      case (digit)
         4'd0:    c = 7'h30;
         4'd1:    c = 7'h31;
         4'd2:    c = 7'h32;
         4'd3:    c = 7'h33;
         4'd4:    c = 7'h34;
         4'd5:    c = 7'h35;
         4'd6:    c = 7'h36;
         4'd7:    c = 7'h37;
         4'd8:    c = 7'h38;
         4'd9:    c = 7'h39;
         4'd10:   c = 7'h41;
         4'd11:   c = 7'h42;
         4'd12:   c = 7'h43;
         4'd13:   c = 7'h44;
         4'd14:   c = 7'h45;
         default: c = 7'h46;
      endcase
      return c;
   endfunction

endpackage

// ===== sv/srtt_dp.sv =====
// ----------------------------------------------------------------------------
// srtt_dp
// Datapath: radix register, magnitude/quotient register with a chunked
// restoring divider, digit stack and the output word register.
// ----------------------------------------------------------------------------
module srtt_dp #(
   parameter int VALUE_BITS = srtt_pkg::VALUE_BITS_DEFAULT,
   localparam int PAD_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [srtt_pkg::RADIX_BITS-1:0]   csr_data,
   input  logic [PAD_BITS-1:0]               req_tdata,
   input  srtt_pkg::srtt_cmd_type            cmd,
   output srtt_pkg::srtt_status_type         status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int CB = srtt_pkg::CHUNK_BITS;

   logic [srtt_pkg::RADIX_BITS-1:0] radix_ff, radix_in;
   logic [srtt_pkg::RADIX_BITS-1:0] radix_eff;
   logic [PAD_BITS-1:0]             mag_ff, mag_in;
   logic [4:0]                      rem_ff, rem_in;
   logic                            neg_ff, neg_in;
   logic [3:0]                      stk_ff [VALUE_BITS];
   logic                            out_valid_ff, out_valid_in;
   logic [srtt_pkg::CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                            out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS-1:0] abs_value;
   logic [4:0]            rem_v;
   logic [4:0]            trial;
   logic [CB-1:0]         qbits;
   logic [PAD_BITS-1:0]   quot_next;

   always_comb begin
      if (radix_ff < srtt_pkg::RADIX_MIN) begin
         radix_eff = srtt_pkg::RADIX_MIN;
      end else if (radix_ff > srtt_pkg::RADIX_MAX) begin
         radix_eff = srtt_pkg::RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   assign value     = req_tdata[VALUE_BITS-1:0];
   assign abs_value = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

   // Restoring division, one chunk of magnitude bits per cycle, MSB first.
   always_comb begin
      rem_v = rem_ff;
      qbits = '0;
      trial = '0;
      for (int i = 0; i < CB; i++) begin
         trial = {rem_v[3:0], mag_ff[PAD_BITS-1-i]};
         if (trial >= radix_eff) begin
            qbits[CB-1-i] = 1'b1;
            rem_v         = trial - radix_eff;
         end else begin
            rem_v = trial;
         end
      end
      quot_next = (mag_ff << CB) | PAD_BITS'(qbits);
   end

   always_comb begin
      radix_in     = radix_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) begin
         radix_in = csr_data;
      end
      if (cmd.load_item) begin
         mag_in = PAD_BITS'(abs_value);
         rem_in = '0;
         neg_in = value[VALUE_BITS-1];
      end
      if (cmd.div_step) begin
         mag_in = quot_next;
         rem_in = cmd.digit_done ? 5'd0 : rem_v;
      end

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = srtt_pkg::CHAR_MINUS;
         out_last_in  = 1'b0;
      end
      if (cmd.emit_digit) begin
         out_valid_in = 1'b1;
         out_char_in  = srtt_pkg::digit_char(stk_ff[0]);
         out_last_in  = cmd.last_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= srtt_pkg::RADIX_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // Digit stack: push on digit completion, pop toward entry zero on emit.
   always_ff @(posedge clock) begin
      if (cmd.digit_done) begin
         stk_ff[0] <= rem_v[3:0];
         for (int i = 1; i < VALUE_BITS; i++) begin
            stk_ff[i] <= stk_ff[i-1];
         end
      end else if (cmd.emit_digit) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stk_ff[i] <= stk_ff[i+1];
         end
      end
   end

   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.quot_zero = (quot_next == '0);
   assign status.negative  = neg_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/srtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtt_ctrl
// Controller: sequences accept, digit division, sign and digit emission,
// and tracks the divide chunk and the stacked digit count.
// ----------------------------------------------------------------------------
module srtt_ctrl #(
   parameter int VALUE_BITS = srtt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  srtt_pkg::srtt_status_type status,
   output srtt_pkg::srtt_cmd_type    cmd
);

   localparam int CHUNKS = (VALUE_BITS + srtt_pkg::CHUNK_BITS - 1) / srtt_pkg::CHUNK_BITS;
   localparam int CH_W   = $clog2(CHUNKS + 1);
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIVIDE = 4'b0010,
      S_SIGN   = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CH_W-1:0]  chunk_ff, chunk_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in   = state_ff;
      chunk_in   = chunk_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd        = '0;

      unique case (state_ff)
         S_IDLE: begin
            // take no word while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_item = 1'b1;
               chunk_in      = '0;
               cnt_in        = '0;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (chunk_ff == CH_W'(CHUNKS - 1)) begin
               cmd.digit_done = 1'b1;
               chunk_in       = '0;
               cnt_in         = cnt_ff + 1'b1;
               if (status.quot_zero) begin
                  state_in = status.negative ? S_SIGN : S_EMIT;
               end
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               cmd.last_digit = (cnt_ff == CNT_W'(1));
               cnt_in         = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chunk_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/signed_radix_to_text_unit.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_text_unit
// Converts a signed integer to ASCII text in a radix of 2 to 16.
// ----------------------------------------------------------------------------
// Each accepted word on req_ is written out on rsp_ as ASCII characters, most
// significant digit first, with a leading '-' for negative values, digits
// above nine as 'A'-'F', and tlast on the final character; zero gives "0" and
// the most negative value is printed from its unsigned magnitude. The radix
// comes from csr_data (reset 10, values below 2 act as 2, above 16 as 16) and
// must be written only while the unit is idle; the unit does not enforce this.
// One word at a time: once a word is accepted, the divider, which resolves
// eight quotient bits per cycle, stacks its digits, and then each character
// (the sign first, if any) is emitted as the output register frees up. The
// next word is taken while the last character still waits.
// ----------------------------------------------------------------------------
module signed_radix_to_text_unit #(
   parameter int VALUE_BITS = srtt_pkg::VALUE_BITS_DEFAULT,
   localparam int PAD_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srtt_pkg::RADIX_BITS-1:0] csr_data,   // radix
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [PAD_BITS-1:0]             req_tdata,  // value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // char_code, zero pad
   output logic                            rsp_tlast
);

   srtt_pkg::srtt_cmd_type    cmd;
   srtt_pkg::srtt_status_type status;

   assign csr_ready = !reset;

   srtt_ctrl #(
      .VALUE_BITS(VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srtt_dp #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/signed_radix_to_text_unit_tb.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_text_unit_tb
// Self-checking bench for the signed radix to text unit.
// ----------------------------------------------------------------------------
// Converts signed words to ASCII in every radix setting, including register
// values below two and above sixteen, and compares each character and its
// tlast against a local model of the conversion. A short directed set at the
// reset radix covers zero, the extremes and sign handling; random phases
// follow, each after a radix write while the unit is idle. Both stream sides
// idle at random, and one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module signed_radix_to_text_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W      = srtt_pkg::VALUE_BITS_DEFAULT;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 18;
   localparam int HOLD_PHASE   = 8;

   localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] MOST_POS = ~MOST_NEG;

   localparam logic [VALUE_W-1:0] DIRECTED_VALUES [17] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, MOST_POS, MOST_NEG, MOST_NEG + 1'b1,
      32'd9, 32'd10, 32'hFFFF_FFF6, 32'd15, 32'hFFFF_FFF1, 32'd16, 32'd255,
      32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, 32'd99999
   };

   localparam int RADIX_PLAN [19] = '{
      16, 2, 0, 1, 31, 17, 3, 7, 10, 5, 12, 13, 8, 14, 11, 9, 4, 6, 15
   };

   typedef struct packed {
      logic [srtt_pkg::CHAR_BITS-1:0] code;
      logic                           tail;
   } text_char_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [srtt_pkg::RADIX_BITS-1:0] csr_data   = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [VALUE_W-1:0]              req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tlast;

   logic [VALUE_W-1:0]              values_pending [$];
   text_char_type                   text_due [$];
   logic [srtt_pkg::RADIX_BITS-1:0] radix_now    = srtt_pkg::RADIX_RESET;
   bit                              req_steady   = 1'b0;
   bit                              rsp_steady   = 1'b0;
   int                              req_idle     = 0;
   int                              rsp_hold     = 0;
   int                              hold_asked   = 0;
   int                              hold_given   = 0;
   int                              error_count  = 0;
   int                              cycle_count  = 0;
   int                              words_queued = 0;
   int                              words_done   = 0;

   signed_radix_to_text_unit #(
      .VALUE_BITS (VALUE_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned radix_in_use(
      input logic [srtt_pkg::RADIX_BITS-1:0] r);
      if (r < srtt_pkg::RADIX_MIN) return 32'(srtt_pkg::RADIX_MIN);
      if (r > srtt_pkg::RADIX_MAX) return 32'(srtt_pkg::RADIX_MAX);
      return 32'(r);
   endfunction

   function automatic void add_char(input logic [srtt_pkg::CHAR_BITS-1:0] code,
                                    input logic tail);
      text_char_type ch;
      ch.code = code;
      ch.tail = tail;
      text_due.insert(text_due.size(), ch);
   endfunction

   // Append the characters of one word, most significant digit first.
   function automatic void spell_value(input logic [VALUE_W-1:0] value,
                                       input logic [srtt_pkg::RADIX_BITS-1:0] r);
      logic [VALUE_W-1:0]             mag;
      logic [3:0]                     digit_buf [VALUE_W];
      logic [srtt_pkg::CHAR_BITS-1:0] code;
      int unsigned                    base;
      int                             n;
      base = radix_in_use(r);
      mag  = value[VALUE_W-1] ? -value : value;
      n    = 0;
      do begin
         digit_buf[n] = 4'(mag % base);
         mag = mag / base;
         n++;
      end while (mag != '0);
      if (value[VALUE_W-1])
         add_char(srtt_pkg::CHAR_MINUS, 1'b0);
      for (int i = n - 1; i >= 0; i--) begin
         code = {3'b000, digit_buf[i]} + ((digit_buf[i] < 4'd10) ? 7'h30 : 7'h37);
         add_char(code, i == 0);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] draw_value(
      input logic [srtt_pkg::RADIX_BITS-1:0] r);
      logic [VALUE_W-1:0] v;
      int unsigned        base;
      int unsigned        steps;
      base = radix_in_use(r);
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2:    v = $urandom_range(0, 40);
         3:    v = -$urandom_range(1, 40);
         4: begin
            // land on or just below a power of the radix
            v     = 1;
            steps = $urandom_range(1, VALUE_W - 1);
            while (steps > 0 && v <= MOST_POS / base) begin
               v = v * base;
               steps--;
            end
            v = v - $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = MOST_NEG + 1'b1;
               default: v = '0;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic void queue_value(input logic [VALUE_W-1:0] v);
      values_pending.insert(values_pending.size(), v);
      words_queued++;
   endfunction

   // Hold until every queued word has come back complete.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (words_done != words_queued || text_due.size() != 0);
   endtask

   task automatic write_radix(input logic [srtt_pkg::RADIX_BITS-1:0] r);
      csr_data  <= r;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      radix_now = r;
   endtask

   // Request side: one word per handshake, random gap before each word.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_idle   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            spell_value(req_tdata, radix_now);
         if (!req_tvalid || req_tready) begin
            if (req_idle > 0) begin
               req_idle   <= req_idle - 1;
               req_tvalid <= 1'b0;
            end else if (values_pending.size() != 0) begin
               req_tdata  <= values_pending.pop_front();
               req_tvalid <= 1'b1;
               req_idle   <= req_steady ? 0 : $urandom_range(0, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: check each character, then draw a random hold.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (text_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected char: expected none, got %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = text_due.pop_front();
               if (want.tail)
                  words_done++;
               if (rsp_tdata !== {1'b0, want.code} || rsp_tlast !== want.tail) begin
                  error_count++;
                  $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                           $time, {1'b0, want.code}, want.tail, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (hold_given != hold_asked) begin
            hold_given <= hold_given + 1;
            rsp_hold   <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= (rsp_hold == 1);
         end else if (rsp_tvalid && rsp_tready && !rsp_steady) begin
            rsp_hold   <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("signed_radix_to_text_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED_VALUES[i])
         queue_value(DIRECTED_VALUES[i]);
      wait_for_idle();
      foreach (RADIX_PLAN[p]) begin
         write_radix(srtt_pkg::RADIX_BITS'(RADIX_PLAN[p]));
         req_steady = (p % 3 == 1);
         rsp_steady = (p % 4 == 2);
         // keep offering words while the result side holds off
         if (p == HOLD_PHASE) begin
            req_steady = 1'b1;
            hold_asked++;
         end
         repeat (PHASE_ITEMS)
            queue_value(draw_value(radix_now));
         wait_for_idle();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("signed_radix_to_text_unit_tb: clean");
      end else begin
         $display("signed_radix_to_text_unit_tb: errors");
      end
      $finish;
   end

endmodule
